### hdl/kcd_pkg.sv
// kcd_pkg: shared types and constants for the key combo detector
// no dependencies
`default_nettype none

package kcd_pkg;

  localparam int MAX_HELD_KEYS_DEF = 8;
  localparam int MAX_COMBOS_DEF    = 16;
  localparam int KEY_WIDTH_DEF     = 16;
  localparam int COMBO_SLOTS       = 8;
  localparam int SLOT_W            = 3;
  localparam int CIDX_W            = 4;
  localparam int CNT_W             = 4;
  localparam int TS_W              = 32;
  localparam int TERM_W            = 16;
  localparam int INUSE_W           = 5;
  localparam int CODE_W            = 16;

  localparam logic [15:0] TERM_RESET = 16'd50;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_SLOT  = 2'd1,
    OP_HDR   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [0:0] {
    CFG_TERM  = 1'b0,
    CFG_INUSE = 1'b1
  } cfg_idx_t;

  // sequencer state, one-hot
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOAD  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

### hdl/key_combo_detector.sv
// key_combo_detector: top level, event handling, combo table and scan sequencer
// depends on kcd_pkg and kcd_cell
//
// channel  | signals                                               | flow
// ---------+-------------------------------------------------------+----------------
// command  | start, busy, opcode, keycode, key_pressed, timestamp,  | in, start/busy
//          | combo_index, slot_index, entry_key_count               |
// result   | done, pass_through, combo_fired, combo_code            | out, strobe
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data              | in, valid/ready
//
// table writes, unused opcodes and expired presses go from start straight to
// S_DONE; a release shifts through the row and waits in S_CHECK.
// a press walks each combo in use: per entry one table read per key slot, each
// key shifted through the row of MAX_HELD_KEYS cells.
// reset clears the window and registers; the table is undefined until written.
// done is a one-cycle strobe; the receiver cannot stall.
`default_nettype none

module key_combo_detector #(
  parameter int MAX_HELD_KEYS = kcd_pkg::MAX_HELD_KEYS_DEF,
  parameter int MAX_COMBOS    = kcd_pkg::MAX_COMBOS_DEF,
  parameter int KEY_WIDTH     = kcd_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  opcode,
  input  wire logic [KEY_WIDTH-1:0]        keycode,
  input  wire logic                        key_pressed,
  input  wire logic [kcd_pkg::TS_W-1:0]    timestamp,
  input  wire logic [kcd_pkg::CIDX_W-1:0]  combo_index,
  input  wire logic [kcd_pkg::SLOT_W-1:0]  slot_index,
  input  wire logic [kcd_pkg::CNT_W-1:0]   entry_key_count,
  output logic                             done,
  output logic                             pass_through,
  output logic                             combo_fired,
  output logic [kcd_pkg::CODE_W-1:0]       combo_code,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [15:0]                 cfg_data
);
  import kcd_pkg::*;

  localparam int HW   = $clog2(MAX_HELD_KEYS + 1);
  localparam int EW   = (MAX_COMBOS > 1) ? $clog2(MAX_COMBOS) : 1;
  localparam int LW   = $clog2(MAX_COMBOS + 1);
  localparam int MEMD = MAX_COMBOS * COMBO_SLOTS;
  localparam int AW   = $clog2(MEMD);
  localparam int WCNT = $clog2(MAX_HELD_KEYS + 2);

  // configuration registers
  logic [TERM_W-1:0]  window_term;
  logic [INUSE_W-1:0] combos_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_term   <= TERM_RESET;
      combos_in_use <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TERM:  window_term   <= cfg_data;
        CFG_INUSE: combos_in_use <= cfg_data[INUSE_W-1:0];
        default:   ;
      endcase
    end
  end

  // combo table memories
  logic [KEY_WIDTH-1:0] key_mem [MEMD];
  logic [CNT_W-1:0]     len_mem [MAX_COMBOS];
  logic [CODE_W-1:0]    out_mem [MAX_COMBOS];
  logic [KEY_WIDTH-1:0] key_rd;
  logic [CNT_W-1:0]     len_rd;
  logic [CODE_W-1:0]    out_rd;
  logic [AW-1:0]        rd_addr;
  logic [EW-1:0]        entry;

  logic accept;
  assign accept = start && !busy;

  logic cidx_ok;
  assign cidx_ok = ({{(32-CIDX_W){1'b0}}, combo_index} < MAX_COMBOS);

  always_ff @(posedge clk) begin
    if (accept && opcode == OP_SLOT && cidx_ok) begin
      key_mem[{combo_index[EW-1:0], slot_index}] <= keycode;
    end
    if (accept && opcode == OP_HDR && cidx_ok) begin
      len_mem[combo_index[EW-1:0]] <= entry_key_count;
      out_mem[combo_index[EW-1:0]] <= keycode;
    end
    key_rd <= key_mem[rd_addr];
    len_rd <= len_mem[entry];
    out_rd <= out_mem[entry];
  end

  // window state
  logic                     window_open;
  logic [TS_W-1:0]          window_start;
  logic [HW-1:0]            held_count;

  // cell chain
  logic                  cell_clear;
  logic                  cell_load [MAX_HELD_KEYS];
  logic                  cv   [MAX_HELD_KEYS+1];
  logic [KEY_WIDTH-1:0]  cd   [MAX_HELD_KEYS+1];
  logic                  ch   [MAX_HELD_KEYS+1];
  logic                  inj_valid;
  logic [KEY_WIDTH-1:0]  inj_key;

  assign cv[0] = inj_valid;
  assign cd[0] = inj_key;
  assign ch[0] = 1'b0;

  for (genvar g = 0; g < MAX_HELD_KEYS; g++) begin : g_cell
    kcd_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk(clk), .rst(rst), .clear(cell_clear), .load(cell_load[g]),
      .load_key(keycode), .cand_valid_in(cv[g]), .cand_in(cd[g]), .hit_in(ch[g]),
      .cand_valid_out(cv[g+1]), .cand_out(cd[g+1]), .hit_out(ch[g+1])
    );
  end

  // sequencer
  state_t              state;
  logic [LW-1:0]       ent_cnt;
  logic [LW-1:0]       limit;
  logic [SLOT_W:0]     slot;
  logic                slot_rd_v;
  logic [SLOT_W:0]     hits;
  logic                miss;
  logic [WCNT-1:0]     drain;
  logic                fire;

  assign limit = ({{(32-INUSE_W){1'b0}}, combos_in_use} > MAX_COMBOS)
               ? LW'(MAX_COMBOS) : combos_in_use[LW-1:0];
  assign entry   = ent_cnt[EW-1:0];
  assign rd_addr = {entry, slot[SLOT_W-1:0]};
  assign busy    = (state != S_IDLE);

  // wrap-around time since the window opened
  logic [TS_W-1:0] elapsed;
  assign elapsed = timestamp - window_start;

  always_comb begin
    cell_clear = 1'b0;
    for (int i = 0; i < MAX_HELD_KEYS; i++) begin
      cell_load[i] = accept && opcode == OP_KEY && key_pressed &&
                     (!window_open ||
                      elapsed <= {{(TS_W-TERM_W){1'b0}}, window_term}) &&
                     (window_open ? held_count : '0) == HW'(i);
    end
    if (accept && opcode == OP_KEY && key_pressed && !window_open) begin
      cell_clear = 1'b1;
    end
    if (fire) begin
      cell_clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    fire <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      window_open  <= 1'b0;
      window_start <= '0;
      held_count   <= '0;
      inj_valid    <= 1'b0;
    end else begin
      inj_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pass_through <= 1'b0;
            combo_fired  <= 1'b0;
            combo_code   <= '0;
            ent_cnt      <= '0;
            slot         <= '0;
            hits         <= '0;
            miss         <= 1'b0;
            slot_rd_v    <= 1'b0;
            drain        <= '0;
            if (opcode == OP_KEY) begin
              pass_through <= 1'b1;
              if (!key_pressed) begin
                // release: shift the key through the held row
                inj_valid <= 1'b1;
                inj_key   <= keycode;
                state     <= S_CHECK;
              end else if (window_open && elapsed > {16'd0, window_term}) begin
                window_open <= 1'b0;
                held_count  <= '0;
                state       <= S_DONE;
              end else begin
                if (!window_open) begin
                  window_open  <= 1'b1;
                  window_start <= timestamp;
                  held_count   <= HW'(1);
                end else if (held_count < HW'(MAX_HELD_KEYS)) begin
                  held_count <= held_count + 1'b1;
                end
                state <= S_LOAD;
              end
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_LOAD: begin
          // next entry header read
          slot      <= '0;
          hits      <= '0;
          miss      <= 1'b0;
          slot_rd_v <= 1'b0;
          drain     <= '0;
          if (ent_cnt >= limit) begin
            state <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue slot reads, inject keys into the chain, count hits
          if (slot < len_rd && slot < (SLOT_W+1)'(COMBO_SLOTS)) begin
            slot <= slot + 1'b1;
          end
          slot_rd_v <= (slot < len_rd) && (slot < (SLOT_W+1)'(COMBO_SLOTS));
          inj_valid <= slot_rd_v;
          inj_key   <= key_rd;
          if (cv[MAX_HELD_KEYS]) begin
            if (ch[MAX_HELD_KEYS]) hits <= hits + 1'b1;
            else miss <= 1'b1;
          end
          if (!slot_rd_v && !inj_valid && slot != '0 &&
              !(slot < len_rd && slot < (SLOT_W+1)'(COMBO_SLOTS))) begin
            drain <= drain + 1'b1;
          end
          if (len_rd == '0 || len_rd > CNT_W'(COMBO_SLOTS) ||
              {{(32-CNT_W){1'b0}}, len_rd} != {{(32-HW){1'b0}}, held_count}) begin
            ent_cnt <= ent_cnt + 1'b1;
            state   <= S_LOAD;
          end else if (drain == WCNT'(MAX_HELD_KEYS + 1)) begin
            if (!miss && hits == len_rd) begin
              combo_fired  <= 1'b1;
              pass_through <= 1'b0;
              combo_code   <= out_rd;
              window_open  <= 1'b0;
              held_count   <= '0;
              fire         <= 1'b1;
              state        <= S_DONE;
            end else begin
              ent_cnt <= ent_cnt + 1'b1;
              state   <= S_LOAD;
            end
          end
        end
        S_CHECK: begin
          // release key reaches the end of the row
          if (cv[MAX_HELD_KEYS]) begin
            if (ch[MAX_HELD_KEYS] && window_open) begin
              window_open <= 1'b0;
              held_count  <= '0;
              fire        <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_fire_flags: assert property (@(posedge clk) disable iff (rst)
    done && combo_fired |-> !pass_through) else $error("fire with pass");
  a_held_max: assert property (@(posedge clk) disable iff (rst)
    held_count <= HW'(MAX_HELD_KEYS)) else $error("held overflow");
  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !window_open && state == S_IDLE |-> held_count == '0)
    else $error("closed window holds keys");

endmodule

`default_nettype wire

### hdl/kcd_cell.sv
// kcd_cell: one held-key cell of the chain
// a candidate key shifts along the row; each cell compares it with its held key
// depends on kcd_pkg
`default_nettype none

module kcd_cell #(
  parameter int KEY_WIDTH = kcd_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 clear,
  input  wire logic                 load,
  input  wire logic [KEY_WIDTH-1:0] load_key,
  input  wire logic                 cand_valid_in,
  input  wire logic [KEY_WIDTH-1:0] cand_in,
  input  wire logic                 hit_in,
  output logic                      cand_valid_out,
  output logic [KEY_WIDTH-1:0]      cand_out,
  output logic                      hit_out
);
  import kcd_pkg::*;

  logic [KEY_WIDTH-1:0] held;
  logic                 occupied;

  // stored key; a load during a clear starts the new window with this key
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (load) begin
      occupied <= 1'b1;
    end else if (clear) begin
      occupied <= 1'b0;
    end
    if (load) begin
      held <= load_key;
    end
  end

  // candidate and running hit travel to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid_out <= 1'b0;
    end else begin
      cand_valid_out <= cand_valid_in;
    end
    cand_out <= cand_in;
    hit_out  <= hit_in | (occupied && held == cand_in);
  end

endmodule

`default_nettype wire

### verif/tb_top.sv
// tb_top: self-checking testbench for key_combo_detector
// depends on kcd_pkg and the key_combo_detector rtl; reads no files
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kcd_pkg::*;

  typedef struct {
    opcode_t     op;
    logic [15:0] key;
    logic        pressed;
    logic [31:0] ts;
    logic [3:0]  cidx;
    logic [2:0]  sidx;
    logic [3:0]  cnt;
  } event_t;

  typedef struct {
    logic        pass;
    logic        fired;
    logic [15:0] code;
  } answer_t;

  typedef struct {
    event_t  ev;
    logic    typed;
    answer_t ans;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [15:0] keycode;
  logic        key_pressed;
  logic [31:0] timestamp;
  logic [3:0]  combo_index;
  logic [2:0]  slot_index;
  logic [3:0]  entry_key_count;
  logic        done;
  logic        pass_through;
  logic        combo_fired;
  logic [15:0] combo_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  key_combo_detector i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .keycode(keycode), .key_pressed(key_pressed), .timestamp(timestamp),
    .combo_index(combo_index), .slot_index(slot_index),
    .entry_key_count(entry_key_count), .done(done), .pass_through(pass_through),
    .combo_fired(combo_fired), .combo_code(combo_code), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the detector state
  logic [15:0] term_sh;
  logic [4:0]  inuse_sh;
  logic        win_open;
  logic [31:0] win_start;
  logic [15:0] held [8];
  int          held_n;
  logic [15:0] slot_key [128];
  logic [3:0]  entry_len [16];
  logic [15:0] entry_code [16];

  answer_t     pending_q [$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          idle_on = 1;
  logic [15:0] key_pool [12];
  logic [31:0] now_ts = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic bit key_held(logic [15:0] k);
    for (int i = 0; i < held_n && i < 8; i++)
      if (held[i] == k) return 1;
    return 0;
  endfunction

  function automatic bit entry_hit(int e);
    int n;
    n = entry_len[e];
    if (n != held_n || n > COMBO_SLOTS || n == 0) return 0;
    for (int i = 0; i < n; i++)
      if (!key_held(slot_key[e*COMBO_SLOTS+i])) return 0;
    return 1;
  endfunction

  // combo detection on one event, updates shadow state
  function automatic answer_t detect_combo(event_t ev);
    answer_t r;
    int lim;
    r = '{0, 0, 0};
    case (ev.op)
      OP_SLOT: slot_key[{ev.cidx, ev.sidx}] = ev.key;
      OP_HDR: begin
        entry_len[ev.cidx] = ev.cnt;
        entry_code[ev.cidx] = ev.key;
      end
      OP_KEY: begin
        r.pass = 1;
        if (!ev.pressed) begin
          if (key_held(ev.key)) begin
            win_open = 0;
            held_n = 0;
          end
          return r;
        end
        if (!win_open) begin
          win_open = 1;
          win_start = ev.ts;
          held_n = 0;
        end else if (ev.ts - win_start > {16'd0, term_sh}) begin
          win_open = 0;
          held_n = 0;
          return r;
        end
        if (held_n < 8) begin
          held[held_n] = ev.key;
          held_n++;
        end
        lim = (inuse_sh > 16) ? 16 : inuse_sh;
        for (int e = 0; e < lim; e++) begin
          if (entry_hit(e)) begin
            r = '{0, 1, entry_code[e]};
            win_open = 0;
            held_n = 0;
            return r;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // command word: random idle, then hold until accepted
  task automatic send_word(event_t ev, bit typed, answer_t ans);
    answer_t want;
    if (idle_on && $urandom_range(99) < 19) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    opcode <= ev.op;
    keycode <= ev.key;
    key_pressed <= ev.pressed;
    timestamp <= ev.ts;
    combo_index <= ev.cidx;
    slot_index <= ev.sidx;
    entry_key_count <= ev.cnt;
    do @(posedge clk); while (busy);
    want = detect_combo(ev);
    pending_q.push_back(typed ? ans : want);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] data);
    start <= 0;
    wait (pending_q.size() == 0);
    repeat (5) @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_TERM) term_sh = data;
    else inuse_sh = data[4:0];
  endtask

  // result checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("tb_top: FAIL");
        $finish;
      end
      if (done) begin
        if (pending_q.size() == 0) report_mismatch("unexpected word", 1, 0);
        else begin
          answer_t w;
          w = pending_q.pop_front();
          if (pass_through !== w.pass) report_mismatch("pass_through", pass_through, w.pass);
          if (combo_fired !== w.fired) report_mismatch("combo_fired", combo_fired, w.fired);
          if (combo_code !== w.code) report_mismatch("combo_code", combo_code, w.code);
        end
      end
    end
  end

  function automatic event_t mk(opcode_t op, logic [15:0] key, logic pr, logic [31:0] ts,
                                logic [3:0] ci, logic [2:0] si, logic [3:0] cn);
    event_t ev;
    ev = '{op, key, pr, ts, ci, si, cn};
    return ev;
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    int p;
    ev = mk(OP_KEY, 16'($urandom), 1'($urandom), $urandom, 4'($urandom),
            3'($urandom), 4'($urandom));
    p = $urandom_range(99);
    if (p < 2) ev.op = OP_NONE;
    else if (p < 7) begin
      ev.op = OP_SLOT;
      ev.key = key_pool[$urandom_range(11)];
    end else if (p < 10) begin
      ev.op = OP_HDR;
      ev.cnt = 4'($urandom_range(0, 4));
    end else begin
      if ($urandom_range(9) != 0) ev.key = key_pool[$urandom_range(11)];
      ev.pressed = ($urandom_range(99) < 75);
      case ($urandom_range(19))
        0: now_ts = $urandom;
        1: now_ts += 32'hFFFF_0000 + $urandom_range(0, 65535);
        2, 3, 4: ;
        default: now_ts += $urandom_range(1, 30);
      endcase
      ev.ts = now_ts;
    end
    return ev;
  endfunction

  initial begin
    stim_row_t rows [$];
    answer_t   none;
    answer_t   pt;
    answer_t   nil;
    logic [15:0] terms [5];
    logic [4:0]  uses [5];
    none = '{0, 0, 0};
    pt = '{1, 0, 0};
    nil = '{0, 0, 0};
    rst = 1;
    start = 0; opcode = OP_KEY; keycode = 0; key_pressed = 0; timestamp = 0;
    combo_index = 0; slot_index = 0; entry_key_count = 0;
    cfg_valid = 0; cfg_index = CFG_TERM; cfg_data = 0;
    term_sh = TERM_RESET; inuse_sh = 0; win_open = 0; win_start = 0; held_n = 0;
    foreach (slot_key[i]) slot_key[i] = 0;
    foreach (entry_len[i]) begin
      entry_len[i] = 0;
      entry_code[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed rows: opcode 3, window open, expiry, wrap, held keys full, releases, table writes
    rows.push_back('{mk(OP_NONE, 16'hFFFF, 1, '1, '1, '1, '1), 1, none});
    rows.push_back('{mk(OP_KEY, 16'h0000, 1, 32'd0, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'hFFFF, 1, 32'd50, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'h1234, 1, 32'd51, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'h0005, 0, 32'd52, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'h0007, 1, 32'hFFFF_FFFF, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'h0008, 1, 32'd31, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'h0007, 0, 32'd32, 0, 0, 0), 1, pt});
    for (int k = 0; k < 9; k++)
      rows.push_back('{mk(OP_KEY, 16'(100 + k), 1, 32'd1000, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'd108, 0, 32'd1001, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_KEY, 16'd100, 0, 32'd1001, 0, 0, 0), 1, pt});
    rows.push_back('{mk(OP_SLOT, 16'hFFFF, 0, 0, 4'hF, 3'h7, 0), 1, nil});
    rows.push_back('{mk(OP_HDR, 16'hFFFF, 0, 0, 4'h0, 0, 4'd8), 1, nil});
    rows.push_back('{mk(OP_HDR, 16'h0000, 0, 0, 4'hF, 0, 4'd0), 1, nil});
    foreach (rows[i]) send_word(rows[i].ev, rows[i].typed, rows[i].ans);

    // fill the whole table before any entry is scanned
    foreach (key_pool[i]) key_pool[i] = 16'($urandom);
    for (int e = 0; e < 16; e++) begin
      int n;
      case ($urandom_range(9))
        0: n = 0;
        1: n = 8;
        2: n = $urandom_range(9, 15);
        default: n = $urandom_range(1, 4);
      endcase
      for (int s = 0; s < 8; s++)
        send_word(mk(OP_SLOT, key_pool[$urandom_range(11)], 1'($urandom), $urandom,
                     4'(e), 3'(s), 4'($urandom)), 0, none);
      send_word(mk(OP_HDR, 16'($urandom), 1'($urandom), $urandom, 4'(e),
                   3'($urandom), 4'(n)), 0, none);
    end

    // random phases over register settings, one phase without idling
    terms = '{16'd50, 16'd0, 16'hFFFF, 16'd200, 16'($urandom_range(0, 100))};
    uses = '{5'd16, 5'd31, 5'd1, 5'd0, 5'($urandom_range(2, 15))};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_TERM, terms[ph]);
      write_reg(CFG_INUSE, {11'($urandom_range(0, 2047)), uses[ph]});
      idle_on = (ph != 2);
      for (int k = 0; k < 210; k++) send_word(rand_event(), 0, none);
    end
    idle_on = 1;
    start <= 0;

    wait (pending_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
